@@ sv/beacon_poll_responder_core_macros.svh @@
// Assertion macros shared by the beacon poll responder RTL.
// Defining ASSERT_OFF turns every assertion into an empty statement.
`ifndef BEACON_POLL_RESPONDER_CORE_MACROS_SVH
`define BEACON_POLL_RESPONDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define BPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/bpr_pkg.sv @@
// Types and constants of the beacon poll responder.
// Used by the interfaces, the front, the job queue and the back end.
package bpr_pkg;

    localparam int LEVEL_W = 16;
    localparam int STEP_W = 10;
    localparam int FLOOR_W = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W = 1;
    localparam int SHOWN_W = 14;
    localparam int CHAN_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FLOOR = 1'd1;

    localparam logic OP_POLL_BYTE = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_QUERY = 8'h3F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE = 8'h31;
    localparam logic [7:0] CHAR_FIVE = 8'h35;
    localparam logic [7:0] STATUS_OK = 8'h40;
    localparam logic [7:0] STATUS_ERR = 8'h42;
    localparam logic [7:0] CSUM_BASE = 8'h20;

    localparam logic [SHOWN_W-1:0] DISPLAY_MAX = 14'd9999;
    localparam logic [STEP_W-1:0] RESET_STEP = 10'd10;
    localparam logic [FLOOR_W-1:0] RESET_FLOOR = 15'd9900;

    typedef struct packed {
        logic [SHOWN_W-1:0] shown;
        logic               err;
        logic [CHAN_W-1:0]  chan;
    } t_job;

endpackage

@@ sv/bpr_ifs.sv @@
// Valid/ready channel interfaces of the beacon poll responder.
// Depends on bpr_pkg for field widths.
interface bpr_in_if import bpr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [7:0]                rx_byte;
    logic signed [LEVEL_W-1:0] chan1_level;
    logic signed [LEVEL_W-1:0] chan2_level;

    modport source (output valid, output op, output rx_byte, output chan1_level,
                    output chan2_level, input ready);
    modport sink (input valid, input op, input rx_byte, input chan1_level,
                  input chan2_level, output ready);
endinterface

interface bpr_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output tx_byte, output last, input ready);
    modport sink (input valid, input tx_byte, input last, output ready);
endinterface

@@ sv/beacon_poll_responder_core.sv @@
// Beacon poll responder top level: poll front, job queue and response back end.
// Depends on bpr_pkg, bpr_ifs, bpr_front, bpr_queue and bpr_back.
//
// Usage: items arrive on i_in (op, rx_byte, chan1_level, chan2_level). A poll
// byte is held until the second byte of the poll arrives; a timeout drops a
// held byte and advances the levels. Each completed poll produces eight bytes
// on o_out, the eighth flagged by last. The ramp step and floor are written
// through i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle.
// The front takes one item per cycle while the two-entry job queue has room.
// The back end sends one byte per cycle while the receiver is ready; a
// completed poll's first byte passes from the queue through the back end's job
// registers into the output register.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and i_in.ready drops once two jobs are waiting.
// Reset (synchronous, active low) returns the channel to 1, clears the poll
// state and all levels, and restores the ramp step of 10 and floor of 9900.
module beacon_poll_responder_core import bpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpr_in_if.sink                i_in,
    bpr_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;
    t_job front_job;
    t_job q_job;

    bpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    bpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    bpr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

@@ sv/bpr_queue.sv @@
// Two-entry job queue between the poll front and the response back end.
// Depends on bpr_pkg and the assertion macros.
`include "beacon_poll_responder_core_macros.svh"

module bpr_queue import bpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    `BPR_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `BPR_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != 2'd0)
    `BPR_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_count != 2'd2)

endmodule

@@ sv/bpr_front.sv @@
// Poll front: accepts items, tracks the poll state, channel and levels,
// and queues one response job per completed poll. Depends on bpr_pkg.
module bpr_front import bpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpr_in_if.sink                i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [STEP_W-1:0]         r_step;
    logic [FLOOR_W-1:0]        r_floor;
    logic [CHAN_W-1:0]         r_channel;
    logic                      r_have;
    logic [7:0]                r_held;
    logic signed [LEVEL_W-1:0] r_fed [2];
    logic signed [LEVEL_W-1:0] r_ramp [3];

    logic                      accept;
    logic                      cmd_sel;
    logic [CHAN_W-1:0]         n_channel;
    logic signed [LEVEL_W-1:0] cur_level;
    logic signed [LEVEL_W:0]   neg_level;
    logic signed [LEVEL_W:0]   neg_floor;
    logic signed [LEVEL_W-1:0] n_ramp [3];

    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && i_in.ready;
    assign o_push = accept && (i_in.op == OP_POLL_BYTE) && r_have;

    assign cmd_sel = (r_held >= CHAR_ONE) && (r_held <= CHAR_FIVE);
    assign n_channel = cmd_sel ? r_held[CHAN_W-1:0] : r_channel;

    always_comb begin
        unique case (n_channel)
            3'd1:    cur_level = r_fed[0];
            3'd2:    cur_level = r_fed[1];
            3'd3:    cur_level = r_ramp[0];
            3'd4:    cur_level = r_ramp[1];
            3'd5:    cur_level = r_ramp[2];
            default: cur_level = '0;
        endcase
    end

    assign neg_level = -$signed({cur_level[LEVEL_W-1], cur_level});

    always_comb begin
        o_job.chan = n_channel;
        o_job.err = (i_in.rx_byte != CHAR_CR) || (!cmd_sel && (r_held != CHAR_QUERY));
        if (neg_level < 0) begin
            o_job.shown = '0;
        end else if (neg_level > $signed({3'b000, DISPLAY_MAX})) begin
            o_job.shown = DISPLAY_MAX;
        end else begin
            o_job.shown = neg_level[SHOWN_W-1:0];
        end
    end

    assign neg_floor = -$signed({2'b00, r_floor});

    always_comb begin
        logic signed [LEVEL_W:0] lv;
        logic signed [LEVEL_W:0] diff;
        for (int k = 0; k < 3; k++) begin
            lv = {r_ramp[k][LEVEL_W-1], r_ramp[k]};
            diff = lv - $signed({{(LEVEL_W + 1 - STEP_W){1'b0}}, r_step});
            if (lv <= neg_floor) begin
                n_ramp[k] = '0;
            end else if (diff < -$signed(17'sd32768)) begin
                n_ramp[k] = 16'sh8000;
            end else begin
                n_ramp[k] = diff[LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= RESET_STEP;
            r_floor <= RESET_FLOOR;
            r_channel <= 3'd1;
            r_have <= 1'b0;
            r_held <= CHAR_SPACE;
            r_fed[0] <= '0;
            r_fed[1] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_ramp[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RAMP_STEP:  r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_RAMP_FLOOR: r_floor <= i_cfg_data[FLOOR_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_in.op == OP_TIMEOUT || r_have) begin
                    r_have <= 1'b0;
                    r_fed[0] <= i_in.chan1_level;
                    r_fed[1] <= i_in.chan2_level;
                    for (int k = 0; k < 3; k++) begin
                        r_ramp[k] <= n_ramp[k];
                    end
                    if (i_in.op == OP_TIMEOUT) begin
                        r_held <= CHAR_SPACE;
                    end else begin
                        r_channel <= n_channel;
                    end
                end else begin
                    r_have <= 1'b1;
                    r_held <= i_in.rx_byte;
                end
            end
        end
    end

endmodule

@@ sv/bpr_back.sv @@
// Response back end: takes jobs from the queue and sends the eight response
// bytes through an output register. Depends on bpr_pkg and the assertion macros.
`include "beacon_poll_responder_core_macros.svh"

module bpr_back import bpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_job    i_q_job,
    output logic    o_q_pop,
    bpr_out_if.source o_out
);

    localparam logic [2:0] IDX_FIRST = 3'd0;
    localparam logic [2:0] IDX_LAST_DIGIT = 3'd3;
    localparam logic [2:0] IDX_STATUS = 3'd4;
    localparam logic [2:0] IDX_CHAN = 3'd5;
    localparam logic [2:0] IDX_CSUM = 3'd6;
    localparam logic [2:0] IDX_CR = 3'd7;

    logic               r_busy;
    logic [2:0]         r_idx;
    logic [SHOWN_W-1:0] r_rem;
    logic               r_err;
    logic [CHAN_W-1:0]  r_chan;
    logic [5:0]         r_sum;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic               adv;
    logic               load;
    logic [SHOWN_W-1:0] pw;
    logic [3:0]         digit;
    logic [SHOWN_W-1:0] sub;
    logic [7:0]         tx;

    assign adv = r_busy && (!r_out_valid || o_out.ready);
    assign load = i_q_valid && (!r_busy || (adv && r_idx == IDX_CR));
    assign o_q_pop = load;

    assign o_out.valid = r_out_valid;
    assign o_out.tx_byte = r_out_byte;
    assign o_out.last = r_out_last;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    pw = 14'd1000;
            2'd1:    pw = 14'd100;
            2'd2:    pw = 14'd10;
            default: pw = 14'd1;
        endcase
    end

    always_comb begin
        digit = '0;
        sub = '0;
        for (int d = 1; d < 10; d++) begin
            if (r_rem >= 14'(d * pw)) begin
                digit = 4'(d);
                sub = 14'(d * pw);
            end
        end
    end

    always_comb begin
        unique case (r_idx) inside
            [IDX_FIRST:IDX_LAST_DIGIT]: tx = CHAR_ZERO + {4'b0000, digit};
            IDX_STATUS: tx = r_err ? STATUS_ERR : STATUS_OK;
            IDX_CHAN:   tx = CHAR_ZERO + {5'b00000, r_chan};
            IDX_CSUM:   tx = CSUM_BASE + {2'b00, r_sum};
            default:    tx = CHAR_CR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= IDX_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_idx <= r_idx + 3'd1;
                if (r_idx == IDX_CR) begin
                    r_busy <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx <= IDX_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= tx;
            r_out_last <= (r_idx == IDX_CR);
            if (r_idx <= IDX_LAST_DIGIT) begin
                r_rem <= r_rem - sub;
            end
            if (r_idx <= IDX_CHAN) begin
                r_sum <= r_sum + tx[5:0];
            end
        end
        if (load) begin
            r_rem <= i_q_job.shown;
            r_err <= i_q_job.err;
            r_chan <= i_q_job.chan;
            r_sum <= '0;
        end
    end

    `BPR_ASSERT_IMP(a_rem_in_range, i_clk, i_rst_n, r_busy && r_idx == IDX_FIRST,
                    r_rem <= DISPLAY_MAX)
    `BPR_ASSERT_IMP(a_digits_done, i_clk, i_rst_n, r_busy && r_idx == IDX_STATUS,
                    r_rem == '0)
    `BPR_ASSERT_NXT(a_last_follows_cr, i_clk, i_rst_n, adv && r_idx == IDX_CR,
                    r_out_valid && r_out_last)
    `BPR_ASSERT_IMP(a_last_is_cr, i_clk, i_rst_n, r_out_valid && r_out_last,
                    r_out_byte == CHAR_CR)

endmodule

@@ test/beacon_poll_responder_core_tb.sv @@
// Self-checking testbench for beacon_poll_responder_core: polls, timeouts and broken
// sequences are driven over several ramp settings, and every response byte is checked.
// Depends on bpr_pkg, bpr_ifs and the beacon_poll_responder_core RTL.
module beacon_poll_responder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_PHASES = 6;
    localparam int HALF_PHASE_ITEMS = 36;

    typedef struct packed {
        logic                      op;
        logic [7:0]                rx_byte;
        logic signed [LEVEL_W-1:0] chan1_level;
        logic signed [LEVEL_W-1:0] chan2_level;
    } t_poll_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_resp_byte;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bpr_in_if  in_if ();
    bpr_out_if out_if ();

    beacon_poll_responder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_poll_item rx_items [$];
    t_resp_byte tx_bytes_due [$];
    t_resp_byte due_byte;
    t_poll_item next_item;

    int   mismatch_count = 0;
    int   cycle_count = 0;
    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   ready_run = 0;
    int   stall_left = 0;

    int          ramp_step_now;
    int          ramp_floor_now;
    int          chan_now;
    logic        cmd_pending;
    logic [7:0]  cmd_held;
    int          fed_now [2];
    int          ramp_now [3];

    always #2 i_clk = ~i_clk;

    function automatic logic signed [LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'(-int'($urandom_range(0, 10500)));
        endcase
    endfunction

    function automatic logic [7:0] rand_command();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_QUERY : 8'(CHAR_ONE + k);
    endfunction

    task automatic push_item(input logic op, input logic [7:0] rx,
                             input logic signed [LEVEL_W-1:0] c1,
                             input logic signed [LEVEL_W-1:0] c2);
        t_poll_item it;
        it.op = op;
        it.rx_byte = rx;
        it.chan1_level = c1;
        it.chan2_level = c2;
        rx_items.push_back(it);
    endtask

    task automatic push_poll(input logic [7:0] cmd, input logic [7:0] term);
        push_item(OP_POLL_BYTE, cmd, rand_level(), rand_level());
        push_item(OP_POLL_BYTE, term, rand_level(), rand_level());
    endtask

    task automatic advance_levels(input t_poll_item it);
        int k;
        fed_now[0] = $signed(it.chan1_level);
        fed_now[1] = $signed(it.chan2_level);
        for (k = 0; k < 3; k++) begin
            if (ramp_now[k] <= -ramp_floor_now) begin
                ramp_now[k] = 0;
            end else begin
                ramp_now[k] = ramp_now[k] - ramp_step_now;
                if (ramp_now[k] < -32768) ramp_now[k] = -32768;
            end
        end
    endtask

    task automatic compute_response(input t_poll_item it);
        logic [7:0] resp [8];
        logic [7:0] status;
        logic [7:0] sum;
        int         shown;
        int         j;
        t_resp_byte rb;
        if (it.op == OP_TIMEOUT) begin
            cmd_pending = 1'b0;
            cmd_held = CHAR_SPACE;
            advance_levels(it);
        end else if (!cmd_pending) begin
            cmd_held = it.rx_byte;
            cmd_pending = 1'b1;
        end else begin
            cmd_pending = 1'b0;
            status = (it.rx_byte == CHAR_CR) ? STATUS_OK : STATUS_ERR;
            if (cmd_held >= CHAR_ONE && cmd_held <= CHAR_FIVE) begin
                chan_now = cmd_held - CHAR_ZERO;
            end else if (cmd_held != CHAR_QUERY) begin
                status = STATUS_ERR;
            end
            case (chan_now)
                1: shown = -fed_now[0];
                2: shown = -fed_now[1];
                3, 4, 5: shown = -ramp_now[chan_now - 3];
                default: shown = 0;
            endcase
            if (shown < 0) shown = 0;
            if (shown > DISPLAY_MAX) shown = DISPLAY_MAX;
            for (j = 3; j >= 0; j--) begin
                resp[j] = CHAR_ZERO + 8'(shown % 10);
                shown = shown / 10;
            end
            advance_levels(it);
            resp[4] = status;
            resp[5] = CHAR_ZERO + 8'(chan_now);
            sum = 8'd0;
            for (j = 0; j < 6; j++) sum = sum + resp[j];
            resp[6] = (sum & 8'h3F) + CSUM_BASE;
            resp[7] = CHAR_CR;
            for (j = 0; j < 8; j++) begin
                rb.tx_byte = resp[j];
                rb.last = (j == 7);
                tx_bytes_due.push_back(rb);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RAMP_STEP) ramp_step_now = value & ((1 << STEP_W) - 1);
        else ramp_floor_now = value & ((1 << FLOOR_W) - 1);
    endtask

    task automatic wait_idle();
        while (rx_items.size() != 0 || in_if.valid || tx_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic gen_random_items(input int count);
        int made;
        int r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_poll(rand_command(), CHAR_CR);
                made += 2;
            end else if (r < 80) begin
                push_poll(8'($urandom_range(0, 255)), CHAR_CR);
                made += 2;
            end else if (r < 86) begin
                push_poll(rand_command(), 8'($urandom_range(0, 255)));
                made += 2;
            end else if (r < 93) begin
                push_item(OP_TIMEOUT, 8'($urandom_range(0, 255)), rand_level(),
                          rand_level());
                made += 1;
            end else begin
                push_item(OP_POLL_BYTE, 8'($urandom_range(0, 255)), rand_level(),
                          rand_level());
                made += 1;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (rx_items.size() > 0) begin
                next_item = rx_items.pop_front();
                in_if.valid <= 1'b1;
                in_if.op <= next_item.op;
                in_if.rx_byte <= next_item.rx_byte;
                in_if.chan1_level <= next_item.chan1_level;
                in_if.chan2_level <= next_item.chan2_level;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_run > 0) begin
            ready_run--;
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(0, 40);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 4);
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (tx_bytes_due.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual tx_byte %h last %b",
                             $time, out_if.tx_byte, out_if.last);
                    mismatch_count++;
                end else begin
                    due_byte = tx_bytes_due.pop_front();
                    if (out_if.tx_byte !== due_byte.tx_byte) begin
                        $display("%0t: tx_byte mismatch, expected %h actual %h",
                                 $time, due_byte.tx_byte, out_if.tx_byte);
                        mismatch_count++;
                    end
                    if (out_if.last !== due_byte.last) begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, due_byte.last, out_if.last);
                        mismatch_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                in_taken = 1'b1;
                compute_response('{in_if.op, in_if.rx_byte, in_if.chan1_level,
                                   in_if.chan2_level});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int step_val;
        int floor_val;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RAMP_STEP;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.op = OP_POLL_BYTE;
        in_if.rx_byte = '0;
        in_if.chan1_level = '0;
        in_if.chan2_level = '0;
        out_if.ready = 1'b0;

        ramp_step_now = RESET_STEP;
        ramp_floor_now = RESET_FLOOR;
        chan_now = 1;
        cmd_pending = 1'b0;
        cmd_held = CHAR_SPACE;
        fed_now = '{0, 0};
        ramp_now = '{0, 0, 0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(OP_TIMEOUT, 8'h00, -16'sd32768, 16'sd32767);
        push_item(OP_POLL_BYTE, CHAR_ONE, -16'sd1234, -16'sd9999);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd10000, 16'sd1);
        push_item(OP_POLL_BYTE, 8'(CHAR_ONE + 1), 16'sd0, -16'sd1);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd32768, -16'sd9999);
        push_item(OP_POLL_BYTE, 8'(CHAR_ONE + 2), 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, 16'sd32767, -16'sd32768);
        push_item(OP_POLL_BYTE, 8'(CHAR_ONE + 3), 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd1, -16'sd10);
        push_item(OP_POLL_BYTE, CHAR_FIVE, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd9998, -16'sd100);
        push_item(OP_POLL_BYTE, CHAR_QUERY, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd5000, -16'sd5);
        push_item(OP_POLL_BYTE, 8'h41, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd10000, -16'sd42);
        push_item(OP_POLL_BYTE, CHAR_ONE, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, 8'h58, -16'sd7, -16'sd32768);
        push_item(OP_POLL_BYTE, 8'h00, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, 8'hFF, -16'sd999, 16'sd32767);
        push_item(OP_POLL_BYTE, 8'hFF, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd1, -16'sd2);
        push_item(OP_POLL_BYTE, 8'(CHAR_ONE + 1), 16'sd0, 16'sd0);
        push_item(OP_TIMEOUT, 8'hFF, -16'sd3000, -16'sd4000);
        push_item(OP_POLL_BYTE, CHAR_CR, 16'sd0, 16'sd0);
        push_item(OP_POLL_BYTE, CHAR_CR, -16'sd1, -16'sd1);
        wait_idle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin step_val = RESET_STEP; floor_val = RESET_FLOOR; end
                1: begin step_val = 1000; floor_val = 1; end
                2: begin step_val = 1; floor_val = 32767; end
                3: begin step_val = 1023; floor_val = 32767; end
                4: begin step_val = 0; floor_val = 0; end
                default: begin
                    step_val = $urandom_range(1, 1000);
                    floor_val = $urandom_range(1, 32767);
                end
            endcase
            if (phase != 0) begin
                write_reg(CFG_RAMP_STEP, ($urandom_range(0, 31) << STEP_W) | step_val);
                write_reg(CFG_RAMP_FLOOR, floor_val);
            end
            gen_random_items(HALF_PHASE_ITEMS);
            wait_idle();
            gen_random_items(HALF_PHASE_ITEMS);
            wait_idle();
        end

        if (mismatch_count == 0 && tx_bytes_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ beacon_poll_responder_core.f @@
+incdir+sv
sv/bpr_pkg.sv
sv/bpr_ifs.sv
sv/bpr_queue.sv
sv/bpr_front.sv
sv/bpr_back.sv
sv/beacon_poll_responder_core.sv
test/beacon_poll_responder_core_tb.sv
